### src/srrip_pkg.sv
// ----------------------------------------------------------------------------
// srrip_pkg
// shared constants for the rrip replacement engine with stream bypass
// ----------------------------------------------------------------------------
`default_nettype none

package srrip_pkg;

    localparam int PC_BITS   = 48;
    localparam int TICK_BITS = 6;

    localparam logic [1:0] RRPV_MAX  = 2'd3;
    localparam logic [1:0] RRPV_LONG = 2'd2;
    localparam logic [1:0] RRPV_MRU  = 2'd0;
    localparam logic [1:0] OUTCOME_INIT = 2'd1;
    localparam logic [1:0] OUTCOME_HOT  = 2'd2;

    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

endpackage

`default_nettype wire

### src/srrip_replacement_with_stream_bypass.sv
// ----------------------------------------------------------------------------
// srrip_replacement_with_stream_bypass
// rrip replacement engine with signature outcome table and per-set stride
// based stream bypass, metadata held in synchronous memories
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid in_ready opcode set_index way_index   | in
//          | phys_addr pc hit random_draw                   |
//  result  | out_valid out_ready victim_way bypassed        | out
//          | inserted_rrpv                                  |
//  config  | cfg_we cfg_wdata (streaming threshold)         | in
//
// a find beat passes the lookup and done states, a hit update the lookup,
// penalty and done states, a miss update also the hot state before done;
// the next beat is taken only once the engine is back in idle; the outcome
// table port (read old, write old, read new) sets the miss path length.
// after reset a clearing pass over max(NUM_SETS, 2**SIGNATURE_BITS) entries
// initializes all memories; no input beat is taken meanwhile.
// a finished result waits in the output register; the next beat is taken
// while it waits, but that beat holds its own result until the slot frees.
`default_nettype none

module srrip_replacement_with_stream_bypass #(
    parameter int NUM_SETS       = 2048,
    parameter int NUM_WAYS       = 16,
    parameter int LEADER_COUNT   = 32,
    parameter int SIGNATURE_BITS = 6,
    parameter int ADDRESS_BITS   = 48,
    localparam int SET_BITS = $clog2(NUM_SETS),
    localparam int WAY_BITS = $clog2(NUM_WAYS)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_wdata,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      opcode,
    input  wire logic [SET_BITS-1:0]       set_index,
    input  wire logic [WAY_BITS-1:0]       way_index,
    input  wire logic [ADDRESS_BITS-1:0]   phys_addr,
    input  wire logic [srrip_pkg::PC_BITS-1:0] pc,
    input  wire logic                      hit,
    input  wire logic [4:0]                random_draw,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [WAY_BITS-1:0]            victim_way,
    output logic                           bypassed,
    output logic [1:0]                     inserted_rrpv
);

    localparam int SB          = SIGNATURE_BITS;
    localparam int SIG_ENTRIES = 1 << SB;
    localparam int STRIDE_BITS = ADDRESS_BITS + 1;
    localparam int ST_W        = ADDRESS_BITS + STRIDE_BITS + 2;
    localparam int CLR_DEPTH   = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
    localparam int CLR_BITS    = $clog2(CLR_DEPTH);
    localparam int TB          = srrip_pkg::TICK_BITS;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_PEN, S_HOT, S_DONE
    } state_t;

    // memories: per-set rrpv row, per-set signature row, per-set stride entry,
    // signature outcome counters
    logic [2*NUM_WAYS-1:0]  rrpv_mem [NUM_SETS];
    logic [SB*NUM_WAYS-1:0] sig_mem  [NUM_SETS];
    logic [ST_W-1:0]        st_mem   [NUM_SETS];
    logic [1:0]             oc_mem   [SIG_ENTRIES];

    logic [2*NUM_WAYS-1:0]  rrpv_rd_reg;
    logic [SB*NUM_WAYS-1:0] sig_rd_reg;
    logic [ST_W-1:0]        st_rd_reg;
    logic [1:0]             oc_rd_reg;

    state_t                  state_reg;
    logic [CLR_BITS-1:0]     clr_reg;
    logic [1:0]              thr_reg;
    logic [TB-1:0]           tick_reg;
    logic                    op_reg;
    logic [SET_BITS-1:0]     set_reg;
    logic [WAY_BITS-1:0]     way_reg;
    logic [ADDRESS_BITS-1:0] addr_reg;
    logic [SB-1:0]           pcs_reg;
    logic                    hit_reg;
    logic                    draw0_reg;
    logic [SB-1:0]           old_reg;
    logic [SB-1:0]           sig_reg;
    logic [1:0]              mono_reg;
    logic [1:0]              pen_reg;
    logic [WAY_BITS-1:0]     res_way_reg;
    logic                    res_byp_reg;
    logic [1:0]              res_rrpv_reg;
    logic                    out_valid_reg;
    logic [WAY_BITS-1:0]     out_way_reg;
    logic                    out_byp_reg;
    logic [1:0]              out_rrpv_reg;

    logic in_fire;
    logic slot_free;

    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    // a new beat is taken whenever the engine is idle
    assign in_ready  = (state_reg == S_IDLE);

    // ---------------- find victim: age row so the max reaches 3 ----------------
    logic                  any3, any2, any1;
    logic [1:0]            top;
    logic [1:0]            age;
    logic [WAY_BITS-1:0]   pick;
    logic [2*NUM_WAYS-1:0] aged_row;

    always_comb
    begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            any3 = any3 | (rrpv_rd_reg[2*w +: 2] == 2'd3);
            any2 = any2 | (rrpv_rd_reg[2*w +: 2] == 2'd2);
            any1 = any1 | (rrpv_rd_reg[2*w +: 2] == 2'd1);
        end
        top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
        age = srrip_pkg::RRPV_MAX - top;
        pick = '0;
        // scan from the top so the lowest matching way wins
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (rrpv_rd_reg[2*w +: 2] == top)
            begin
                pick = WAY_BITS'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged_row[2*w +: 2] = rrpv_rd_reg[2*w +: 2] + age;
        end
    end

    // ---------------- stride detector ----------------
    logic [ADDRESS_BITS-1:0] prev_addr;
    logic [STRIDE_BITS-1:0]  prev_stride;
    logic [1:0]              mono_old;
    logic [STRIDE_BITS-1:0]  stride;
    logic                    stride_match;
    logic [1:0]              mono_new;

    always_comb
    begin
        prev_addr   = st_rd_reg[ST_W-1 -: ADDRESS_BITS];
        prev_stride = st_rd_reg[STRIDE_BITS+1:2];
        mono_old    = st_rd_reg[1:0];
        stride      = (prev_addr == '0) ? '0
                    : ({1'b0, addr_reg} - {1'b0, prev_addr});
        stride_match = (prev_addr != '0) && (stride != '0) && (stride == prev_stride);
        if (stride_match)
        begin
            mono_new = (mono_old == 2'd3) ? mono_old : mono_old + 2'd1;
        end
        else
        begin
            mono_new = (mono_old == 2'd0) ? mono_old : mono_old - 2'd1;
        end
    end

    // ---------------- signature of the new block ----------------
    logic [TB-1:0]    tick_inc;
    logic [SB+TB-1:0] sig_wide;
    logic [SB-1:0]    new_sig;
    logic [SB-1:0]    old_sig;

    assign tick_inc = tick_reg + TB'(1);
    assign sig_wide = {{TB{1'b0}}, pcs_reg} ^ {{SB{1'b0}}, tick_inc};
    assign new_sig  = sig_wide[SB-1:0];
    assign old_sig  = sig_rd_reg[SB*way_reg +: SB];

    // ---------------- outcome counter update and insertion ----------------
    logic [1:0] pen_val;
    logic [1:0] sig_oc;
    logic       hot;
    logic       streaming;
    logic       leader;
    logic       byp;
    logic [1:0] placed;

    always_comb
    begin
        if (hit_reg)
        begin
            pen_val = (oc_rd_reg == 2'd3) ? oc_rd_reg : oc_rd_reg + 2'd1;
        end
        else
        begin
            pen_val = (oc_rd_reg == 2'd0) ? oc_rd_reg : oc_rd_reg - 2'd1;
        end
        // new signature counter, seen after the eviction penalty
        sig_oc    = (sig_reg == old_reg) ? pen_reg : oc_rd_reg;
        hot       = (sig_oc >= srrip_pkg::OUTCOME_HOT);
        streaming = (mono_reg >= thr_reg);
        leader    = (set_reg >= SET_BITS'(NUM_SETS - LEADER_COUNT));
        byp       = streaming && !hot;
        if (byp)
        begin
            placed = srrip_pkg::RRPV_MAX;
        end
        else if (hot)
        begin
            placed = srrip_pkg::RRPV_MRU;
        end
        else if (leader && draw0_reg)
        begin
            placed = srrip_pkg::RRPV_MRU;
        end
        else
        begin
            placed = srrip_pkg::RRPV_LONG;
        end
    end

    // ---------------- memory port control ----------------
    logic                  rrpv_we;
    logic [SET_BITS-1:0]   row_wa;
    logic [2*NUM_WAYS-1:0] rrpv_wd;
    logic                  sig_we;
    logic [SB*NUM_WAYS-1:0] sig_wd;
    logic                  st_we;
    logic [ST_W-1:0]       st_wd;
    logic                  oc_we;
    logic [SB-1:0]         oc_wa;
    logic [1:0]            oc_wd;
    logic                  oc_re;
    logic [SB-1:0]         oc_ra;

    always_comb
    begin
        rrpv_we = 1'b0;
        sig_we  = 1'b0;
        st_we   = 1'b0;
        oc_we   = 1'b0;
        oc_re   = 1'b0;
        row_wa  = set_reg;
        rrpv_wd = rrpv_rd_reg;
        sig_wd  = sig_rd_reg;
        st_wd   = {addr_reg, stride, mono_new};
        oc_wa   = old_reg;
        oc_wd   = pen_val;
        oc_ra   = old_sig;
        case (state_reg)
            S_CLEAR:
            begin
                rrpv_we = 1'b1;
                sig_we  = 1'b1;
                st_we   = 1'b1;
                oc_we   = 1'b1;
                row_wa  = clr_reg[SET_BITS-1:0];
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    rrpv_wd[2*w +: 2] = srrip_pkg::RRPV_LONG;
                end
                sig_wd  = '0;
                st_wd   = '0;
                oc_wa   = clr_reg[SB-1:0];
                oc_wd   = srrip_pkg::OUTCOME_INIT;
            end
            S_LOOK:
            begin
                if (op_reg == srrip_pkg::OP_FIND)
                begin
                    rrpv_we = 1'b1;
                    rrpv_wd = aged_row;
                end
                else
                begin
                    st_we = 1'b1;
                    oc_re = 1'b1;
                    oc_ra = old_sig;
                    if (hit_reg)
                    begin
                        rrpv_we = 1'b1;
                        rrpv_wd[2*way_reg +: 2] = srrip_pkg::RRPV_MRU;
                    end
                    else
                    begin
                        sig_we = 1'b1;
                        sig_wd[SB*way_reg +: SB] = new_sig;
                    end
                end
            end
            S_PEN:
            begin
                oc_we = 1'b1;
                oc_re = 1'b1;
                oc_ra = sig_reg;
            end
            S_HOT:
            begin
                rrpv_we = 1'b1;
                rrpv_wd[2*way_reg +: 2] = placed;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rrpv_we)
        begin
            rrpv_mem[row_wa] <= rrpv_wd;
        end
        if (sig_we)
        begin
            sig_mem[row_wa] <= sig_wd;
        end
        if (st_we)
        begin
            st_mem[row_wa] <= st_wd;
        end
        if (oc_we)
        begin
            oc_mem[oc_wa] <= oc_wd;
        end
        if (in_fire)
        begin
            rrpv_rd_reg <= rrpv_mem[set_index];
            sig_rd_reg  <= sig_mem[set_index];
            st_rd_reg   <= st_mem[set_index];
        end
        if (oc_re)
        begin
            oc_rd_reg <= oc_mem[oc_ra];
        end
    end

    // ---------------- control and result registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            thr_reg       <= 2'd2;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            // a refill from the done state takes over the slot itself
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CLR_BITS'(1);
                    if (clr_reg == CLR_BITS'(CLR_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg    <= opcode;
                        set_reg   <= set_index;
                        way_reg   <= way_index;
                        addr_reg  <= phys_addr;
                        pcs_reg   <= pc[SB+1:2];
                        hit_reg   <= hit;
                        draw0_reg <= (random_draw == 5'd0);
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (op_reg == srrip_pkg::OP_FIND)
                    begin
                        res_way_reg  <= pick;
                        res_byp_reg  <= 1'b0;
                        res_rrpv_reg <= 2'd0;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        tick_reg  <= tick_inc;
                        old_reg   <= old_sig;
                        sig_reg   <= new_sig;
                        mono_reg  <= mono_new;
                        state_reg <= S_PEN;
                    end
                end
                S_PEN:
                begin
                    pen_reg <= pen_val;
                    if (hit_reg)
                    begin
                        res_way_reg  <= '0;
                        res_byp_reg  <= 1'b0;
                        res_rrpv_reg <= srrip_pkg::RRPV_MRU;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_HOT;
                    end
                end
                S_HOT:
                begin
                    res_way_reg  <= '0;
                    res_byp_reg  <= byp;
                    res_rrpv_reg <= placed;
                    state_reg    <= S_DONE;
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_way_reg   <= res_way_reg;
                        out_byp_reg   <= res_byp_reg;
                        out_rrpv_reg  <= res_rrpv_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign victim_way    = out_way_reg;
    assign bypassed      = out_byp_reg;
    assign inserted_rrpv = out_rrpv_reg;

    // ---------------- assertions ----------------
    // an accepted beat always goes straight to the metadata lookup
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_LOOK))
        else $error("accepted beat did not start lookup");

    // a bypass is always an insertion at the distant rrpv
    a_bypass_far: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!bypassed || (inserted_rrpv == srrip_pkg::RRPV_MAX)))
        else $error("bypass without distant insertion");

    // the chosen victim reaches rrpv 3 after aging
    a_victim_aged: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_LOOK) && (op_reg == srrip_pkg::OP_FIND))
        |-> (aged_row[2*pick +: 2] == srrip_pkg::RRPV_MAX))
        else $error("victim not at distant rrpv");

    // no beat is taken while the memories are being cleared
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("beat accepted during clearing pass");

endmodule

`default_nettype wire
